@@ rtl/mcap_pkg.sv @@
// shared types and constants for the memory card address port
// used by mcap_ctrl, mcap_datapath and memory_card_address_port
`timescale 1ns / 1ps
`default_nettype none

package mcap_pkg;

  // default number of ram address bits (16 to 24)
  localparam int RAM_ADDR_BITS_DEF = 20;

  // bus register indexes
  localparam logic [3:0] REG_ADDR_LO  = 4'd0;
  localparam logic [3:0] REG_ADDR_MID = 4'd1;
  localparam logic [3:0] REG_ADDR_HI  = 4'd2;
  localparam logic [3:0] REG_DATA     = 4'd3;
  localparam logic [3:0] REG_BANK     = 4'd15;

  // bus ops
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic CFG_SIZE_LOG2   = 1'b0;
  localparam logic CFG_BANK_ENABLE = 1'b1;

  localparam logic [4:0] SIZE_LOG2_RESET   = 5'd20;
  localparam logic       BANK_ENABLE_RESET = 1'b1;

  localparam logic [7:0] BYTE_MSB_MASK = 8'h80;
  localparam logic [7:0] NIBBLE_HI     = 8'hF0;
  localparam logic [7:0] NIBBLE_LO     = 8'h0F;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_en;  // write zero at the clear address and step it
    logic accept;    // an item is taken this cycle
    logic load_ram;  // load the result register from ram read data
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/mcap_ctrl.sv @@
// controller state machine: reset clear pass, item acceptance, result valid
// depends on mcap_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcap_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          op,
  input  wire logic [3:0]    reg_sel,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire logic          clear_last,
  output mcap_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT
  } state_t;

  state_t state;
  logic   ram_rd;
  logic   accept;

  assign ram_rd   = (op == mcap_pkg::OP_READ) && (reg_sel == mcap_pkg::REG_DATA);
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.clear_en = (state == ST_CLEAR);
  assign cmd.accept   = accept;
  assign cmd.load_ram = (state == ST_RD_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept && ram_rd) state <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase

      if ((accept && !ram_rd) || state == ST_RD_WAIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // no item is taken during the clear pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during ram clear");

  // ram read data always lands as a valid result
  a_rd_wait_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_WAIT) |=> out_valid)
    else $error("ram read result lost");

  // a register item gives its result in the next cycle
  a_reg_item_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !ram_rd) |=> (out_valid && state == ST_IDLE))
    else $error("register item result missing");

  // result register never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_WAIT) |-> ($past(out_valid) == 1'b0 || $past(out_ready) == 1'b1))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/mcap_datapath.sv @@
// datapath: address counter, bank select, config registers, ram and result register
// depends on mcap_pkg, driven by mcap_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module mcap_datapath #(
  parameter int RAM_ADDR_BITS = mcap_pkg::RAM_ADDR_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mcap_pkg::cmd_t cmd,
  input  wire logic          op,
  input  wire logic [3:0]    reg_sel,
  input  wire logic [7:0]    wr_byte,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [4:0]    cfg_data,
  output logic [7:0]         rd_byte,
  output logic               clear_last
);

  localparam int RamDepth = 1 << RAM_ADDR_BITS;

  logic [7:0]               ram [RamDepth];
  logic [7:0]               ram_q;
  logic [RAM_ADDR_BITS-1:0] clr_addr;
  logic [23:0]              addr;
  logic [23:0]              addr_next;
  logic                     upper_bank;
  logic [4:0]               size_log2;
  logic                     bank_en;
  logic [4:0]               eff_size;
  logic [RAM_ADDR_BITS-1:0] ram_idx;
  logic [3:0]               hi_nib;
  logic [7:0]               rd_comb;
  logic [7:0]               b0, b1, b2, nb0, nb1, nb2;
  logic                     carry0, carry1;
  logic                     is_wr;
  logic                     ram_wr;

  assign is_wr  = (op == mcap_pkg::OP_WRITE);
  assign ram_wr = cmd.accept && is_wr && (reg_sel == mcap_pkg::REG_DATA);
  assign clear_last = &clr_addr;

  assign eff_size = (size_log2 > 5'(RAM_ADDR_BITS)) ? 5'(RAM_ADDR_BITS) : size_log2;

  always_comb begin
    for (int i = 0; i < RAM_ADDR_BITS; i++) begin
      ram_idx[i] = addr[i] & (5'(i) < eff_size);
    end
    // address bits 20..23 at or above the size read as set
    for (int k = 0; k < 4; k++) begin
      hi_nib[k] = (5'(20 + k) >= eff_size);
    end
  end

  assign b0 = addr[7:0];
  assign b1 = addr[15:8];
  assign b2 = addr[23:16];

  // address byte writes with carry into the next byte on bit 7 falling
  always_comb begin
    nb0    = b0;
    nb1    = b1;
    nb2    = b2;
    carry0 = 1'b0;
    carry1 = 1'b0;
    case (reg_sel)
      mcap_pkg::REG_ADDR_LO: begin
        nb0    = wr_byte;
        carry0 = |(b0 & mcap_pkg::BYTE_MSB_MASK) && !(|(wr_byte & mcap_pkg::BYTE_MSB_MASK));
        nb1    = carry0 ? b1 + 8'd1 : b1;
        carry1 = carry0 && |(b1 & mcap_pkg::BYTE_MSB_MASK)
                 && !(|(nb1 & mcap_pkg::BYTE_MSB_MASK));
        nb2    = carry1 ? b2 + 8'd1 : b2;
      end
      mcap_pkg::REG_ADDR_MID: begin
        nb1    = wr_byte;
        carry1 = |(b1 & mcap_pkg::BYTE_MSB_MASK) && !(|(wr_byte & mcap_pkg::BYTE_MSB_MASK));
        nb2    = carry1 ? b2 + 8'd1 : b2;
      end
      mcap_pkg::REG_ADDR_HI: begin
        nb2 = wr_byte;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    addr_next = addr;
    case (reg_sel)
      mcap_pkg::REG_ADDR_LO, mcap_pkg::REG_ADDR_MID, mcap_pkg::REG_ADDR_HI: begin
        if (is_wr) addr_next = {nb2, nb1, nb0};
      end
      mcap_pkg::REG_DATA: begin
        addr_next = addr + 24'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_comb = 8'd0;
    if (!is_wr) begin
      case (reg_sel)
        mcap_pkg::REG_ADDR_LO:  rd_comb = b0;
        mcap_pkg::REG_ADDR_MID: rd_comb = b1;
        mcap_pkg::REG_ADDR_HI:  rd_comb = (b2 & mcap_pkg::NIBBLE_LO)
                                          | (b2 & mcap_pkg::NIBBLE_HI)
                                          | {hi_nib, 4'd0};
        mcap_pkg::REG_BANK:     rd_comb = {7'd0, upper_bank};
        default:                rd_comb = 8'd0;
      endcase
    end
  end

  // single port ram, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      ram[clr_addr] <= 8'd0;
    end else if (ram_wr) begin
      ram[ram_idx] <= wr_byte;
    end
    if (cmd.accept) ram_q <= ram[ram_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      addr       <= 24'd0;
      upper_bank <= 1'b0;
      size_log2  <= mcap_pkg::SIZE_LOG2_RESET;
      bank_en    <= mcap_pkg::BANK_ENABLE_RESET;
    end else begin
      if (cmd.clear_en) clr_addr <= clr_addr + 1'b1;
      if (cmd.accept) begin
        addr <= addr_next;
        if (is_wr && reg_sel == mcap_pkg::REG_BANK && bank_en) upper_bank <= wr_byte[0];
      end
      if (cfg_we) begin
        case (cfg_index)
          mcap_pkg::CFG_SIZE_LOG2:   size_log2 <= cfg_data;
          mcap_pkg::CFG_BANK_ENABLE: bank_en   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ram) begin
      rd_byte <= ram_q;
    end else if (cmd.accept) begin
      rd_byte <= rd_comb;
    end
  end

endmodule

`default_nettype wire

@@ rtl/memory_card_address_port.sv @@
// top level of the memory card address port: controller plus datapath
// depends on mcap_pkg, mcap_ctrl and mcap_datapath
//
//   channel   handshake              payload
//   input     in_valid / in_ready    op, reg_sel, wr_byte
//   result    out_valid / out_ready  rd_byte
//   config    cfg_we                 cfg_index, cfg_data
//
// a register access loads the result register when the item is taken, a read of the
// data register first goes through the registered ram read port and then the result register
// after reset a clear pass writes zero to every ram byte
// with in_ready low; config writes are taken throughout
// a new item is taken while the last result waits if that result is taken the same cycle
`timescale 1ns / 1ps
`default_nettype none

module memory_card_address_port #(
  parameter int RAM_ADDR_BITS = mcap_pkg::RAM_ADDR_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [3:0] reg_sel,
  input  wire logic [7:0] wr_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      rd_byte,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data
);

  mcap_pkg::cmd_t cmd;
  logic           clear_last;

  mcap_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .reg_sel    (reg_sel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .clear_last (clear_last),
    .cmd        (cmd)
  );

  mcap_datapath #(
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .reg_sel    (reg_sel),
    .wr_byte    (wr_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rd_byte    (rd_byte),
    .clear_last (clear_last)
  );

endmodule

`default_nettype wire
